/* rtl/per_thread_shadow_call_stack_top_macros.svh */
// assertion macros for the shadow call stack top level
// expects clk_i and rst_ni in the scope of the module that includes it
`ifndef PER_THREAD_SHADOW_CALL_STACK_TOP_MACROS_SVH
`define PER_THREAD_SHADOW_CALL_STACK_TOP_MACROS_SVH

// plain property, checked on every rising edge outside reset
`define PTSCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define PTSCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/ptscs_pkg.sv */
// package for the per-thread shadow call stack
// sizes, field widths, status and mode codes, slot action and state types
package ptscs_pkg;

  localparam int THREAD_SLOTS = 16;
  localparam int STACK_DEPTH  = 64;

  localparam int MODE_W   = 2;
  localparam int TID_W    = 22;
  localparam int ADDR_W   = 64;
  localparam int SEL_W    = 4;
  localparam int LVL_W    = 6;
  localparam int STATUS_W = 3;
  localparam int DEPTH_W  = 7;

  localparam int SLOT_W    = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int IDX_W     = $clog2(STACK_DEPTH);
  localparam int FILL_W    = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W     = (FILL_W > LVL_W) ? FILL_W : LVL_W;
  localparam int MEM_DEPTH = THREAD_SLOTS * STACK_DEPTH;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam logic [MODE_W-1:0] MODE_ENTER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EXIT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STS_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 3'd2;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STS_MISMATCH  = 3'd4;
  localparam logic [STATUS_W-1:0] STS_RANGE     = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_FIN  = 2'b10
  } state_e;

  // what the update cycle does with the chosen slot
  typedef enum logic [2:0] {
    ACT_ZERO,  // error answer with empty owner, depth and entry fields
    ACT_PUSH,
    ACT_POP,
    ACT_OVF,
    ACT_READ,
    ACT_LVL    // read below the bottom
  } act_e;

  function automatic logic [MEM_AW-1:0] mem_addr(input logic [SLOT_W-1:0] slot,
                                                 input logic [IDX_W-1:0] idx);
    return MEM_AW'(MEM_AW'(slot) * MEM_AW'(STACK_DEPTH)) + MEM_AW'(idx);
  endfunction

endpackage

/* rtl/per_thread_shadow_call_stack_top.sv */
// Per-thread shadow call stack: slot owner and fill registers plus one
// stack memory (THREAD_SLOTS x STACK_DEPTH entries of 64 bits).
// Usage:
//  - input channel in_valid_i / in_stall_o carries one event item: enter
//    (push), exit (pop and check) or read of an entry below a stack top.
//  - output channel out_valid_o / out_stall_i returns one result item per
//    input item, in order.
//  - an item accepted at one edge has its result valid after the next edge,
//    provided the output register is free.
//  - a new item is taken only after the last one has left the update cycle:
//    the accept cycle matches the thread against the slot owners and reads the
//    stack memory, the update cycle compares, writes the memory and updates owner and fill.
//  - while the update cycle waits for a stalled output register, the input
//    is stalled too; a result that is waiting holds its value.
//  - reset frees all slots and empties all stacks at once; the memory is
//    not cleared, as only entries below a fill are ever read.
// Depends on ptscs_pkg and per_thread_shadow_call_stack_top_macros.svh.
`include "per_thread_shadow_call_stack_top_macros.svh"

module per_thread_shadow_call_stack_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ptscs_pkg::MODE_W-1:0]      mode_i,
  input  logic [ptscs_pkg::TID_W-1:0]       thread_id_i,
  input  logic [ptscs_pkg::ADDR_W-1:0]      func_addr_i,
  input  logic [ptscs_pkg::SEL_W-1:0]       slot_sel_i,
  input  logic [ptscs_pkg::LVL_W-1:0]       level_sel_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ptscs_pkg::STATUS_W-1:0]    status_o,
  output logic [ptscs_pkg::SEL_W-1:0]       slot_o,
  output logic [ptscs_pkg::TID_W-1:0]       owner_id_o,
  output logic [ptscs_pkg::DEPTH_W-1:0]     stack_depth_o,
  output logic [ptscs_pkg::ADDR_W-1:0]      entry_addr_o
);
  import ptscs_pkg::*;

  state_e              state_q, state_d;
  logic [TID_W-1:0]    slot_owner_q [THREAD_SLOTS];
  logic [FILL_W-1:0]   slot_fill_q  [THREAD_SLOTS];
  logic [ADDR_W-1:0]   stack_mem    [MEM_DEPTH];
  logic [ADDR_W-1:0]   rda_q, rdb_q;

  // item held for the update cycle
  act_e                act_q, act_d;
  logic [STATUS_W-1:0] sts_q, sts_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [SEL_W-1:0]    slot4_q, slot4_d;
  logic [TID_W-1:0]    sowner_q, sowner_d;
  logic [FILL_W-1:0]   sfill_q, sfill_d;
  logic [TID_W-1:0]    tid_q;
  logic [ADDR_W-1:0]   addr_q;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [SEL_W-1:0]    out_slot_q, out_slot_d;
  logic [TID_W-1:0]    out_owner_q, out_owner_d;
  logic [DEPTH_W-1:0]  out_depth_q, out_depth_d;
  logic [ADDR_W-1:0]   out_entry_q, out_entry_d;

  logic                acc, fin_go;
  logic [MEM_AW-1:0]   raddr_a, raddr_b, waddr;
  logic                own_hit, free_hit;
  logic [SLOT_W-1:0]   own_idx, free_idx;
  logic                owner_we;
  logic [TID_W-1:0]    owner_wd;
  logic [FILL_W-1:0]   fill_wd;
  logic                pop_ok;

  assign acc    = in_valid_i && !in_stall_o;
  assign fin_go = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (state_q != S_IDLE);

  // lowest slot owned by the thread, lowest free slot
  always_comb begin
    own_hit  = 1'b0;
    free_hit = 1'b0;
    own_idx  = '0;
    free_idx = '0;
    for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
      if (slot_owner_q[i] == thread_id_i) begin
        own_hit = 1'b1;
        own_idx = SLOT_W'(i);
      end
      if (slot_owner_q[i] == '0) begin
        free_hit = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  // decode of the accepted item and the memory read addresses
  always_comb begin
    logic [FILL_W-1:0] f;
    logic [IDX_W-1:0]  idx_a;
    act_d    = ACT_ZERO;
    sts_d    = STS_OK;
    slot_d   = '0;
    slot4_d  = '0;
    idx_a    = '0;
    unique case (mode_i)
      MODE_ENTER: begin
        if (thread_id_i == '0) begin
          sts_d = STS_NOT_FOUND;
        end else if (own_hit || free_hit) begin
          slot_d = own_hit ? own_idx : free_idx;
          act_d  = (slot_fill_q[slot_d] == FILL_W'(STACK_DEPTH)) ? ACT_OVF : ACT_PUSH;
        end else begin
          sts_d = STS_FULL;
        end
      end
      MODE_EXIT: begin
        slot_d = own_idx;
        if (thread_id_i == '0 || !own_hit || slot_fill_q[own_idx] == '0) begin
          sts_d  = STS_NOT_FOUND;
          slot_d = '0;
        end else begin
          act_d = ACT_POP;
        end
      end
      MODE_READ: begin
        if (int'(slot_sel_i) >= THREAD_SLOTS) begin
          sts_d   = STS_RANGE;
          slot4_d = slot_sel_i;
        end else begin
          slot_d = SLOT_W'(slot_sel_i);
          act_d  = (CMP_W'(level_sel_i) < CMP_W'(slot_fill_q[slot_d])) ? ACT_READ : ACT_LVL;
        end
      end
      default: begin
        sts_d = STS_RANGE;
      end
    endcase
    if (act_d != ACT_ZERO) begin
      slot4_d = SEL_W'(slot_d);
    end
    f        = slot_fill_q[slot_d];
    sowner_d = (act_d == ACT_ZERO) ? '0 : slot_owner_q[slot_d];
    sfill_d  = (act_d == ACT_ZERO) ? '0 : f;
    if (act_d == ACT_READ) begin
      idx_a = IDX_W'(CMP_W'(f) - CMP_W'(level_sel_i) - CMP_W'(1));
    end else begin
      idx_a = IDX_W'(f - FILL_W'(1));
    end
    raddr_a = mem_addr(slot_d, idx_a);
    // entry that becomes the top after a pop
    raddr_b = mem_addr(slot_d, IDX_W'(f - FILL_W'(2)));
  end

  // update cycle: result and write-back
  always_comb begin
    pop_ok       = (rda_q == addr_q);
    owner_we     = 1'b0;
    owner_wd     = sowner_q;
    fill_wd      = sfill_q;
    out_status_d = sts_q;
    out_slot_d   = slot4_q;
    out_owner_d  = sowner_q;
    out_depth_d  = DEPTH_W'(sfill_q);
    out_entry_d  = '0;
    case (act_q)
      ACT_PUSH: begin
        owner_we     = 1'b1;
        owner_wd     = tid_q;
        fill_wd      = sfill_q + FILL_W'(1);
        out_status_d = STS_OK;
        out_owner_d  = tid_q;
        out_depth_d  = DEPTH_W'(fill_wd);
        out_entry_d  = addr_q;
      end
      ACT_POP: begin
        if (pop_ok) begin
          owner_we     = 1'b1;
          fill_wd      = sfill_q - FILL_W'(1);
          owner_wd     = (fill_wd == '0) ? '0 : sowner_q;
          out_status_d = STS_OK;
          out_owner_d  = owner_wd;
          out_depth_d  = DEPTH_W'(fill_wd);
          out_entry_d  = (fill_wd == '0) ? '0 : rdb_q;
        end else begin
          out_status_d = STS_MISMATCH;
          out_entry_d  = rda_q;
        end
      end
      ACT_OVF: begin
        out_status_d = STS_OVERFLOW;
        out_entry_d  = rda_q;
      end
      ACT_READ: begin
        out_status_d = STS_OK;
        out_entry_d  = rda_q;
      end
      ACT_LVL: begin
        out_status_d = STS_RANGE;
      end
      default: begin
        out_status_d = sts_q;
      end
    endcase
  end

  assign waddr = mem_addr(slot_q, IDX_W'(sfill_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (acc) state_d = S_FIN;
      S_FIN:   if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // reads only at accept and writes only in the update cycle, so the two
  // never meet on the same entry
  always_ff @(posedge clk_i) begin
    if (fin_go && act_q == ACT_PUSH) begin
      stack_mem[waddr] <= addr_q;
    end
    if (acc) begin
      rda_q <= stack_mem[raddr_a];
      rdb_q <= stack_mem[raddr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < THREAD_SLOTS; i++) begin
        slot_owner_q[i] <= '0;
        slot_fill_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (fin_go && owner_we) begin
        slot_owner_q[slot_q] <= owner_wd;
        slot_fill_q[slot_q]  <= fill_wd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      act_q    <= act_d;
      sts_q    <= sts_d;
      slot_q   <= slot_d;
      slot4_q  <= slot4_d;
      sowner_q <= sowner_d;
      sfill_q  <= sfill_d;
      tid_q    <= thread_id_i;
      addr_q   <= func_addr_i;
    end
    if (fin_go) begin
      out_status_q <= out_status_d;
      out_slot_q   <= out_slot_d;
      out_owner_q  <= out_owner_d;
      out_depth_q  <= out_depth_d;
      out_entry_q  <= out_entry_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign slot_o        = out_slot_q;
  assign owner_id_o    = out_owner_q;
  assign stack_depth_o = out_depth_q;
  assign entry_addr_o  = out_entry_q;

  // a slot is owned exactly when its stack holds entries
  `PTSCS_ASSERT_IMP(a_owner_fill, state_q == S_FIN, (sowner_q == '0) == (sfill_q == '0), "owner and fill disagree")
  `PTSCS_ASSERT_IMP(a_push_room, fin_go && act_q == ACT_PUSH, sfill_q < FILL_W'(STACK_DEPTH), "push into a full stack")
  `PTSCS_ASSERT_IMP(a_pop_nonempty, state_q == S_FIN && act_q == ACT_POP, sfill_q != '0, "pop from an empty stack")

endmodule

/* verif/tb.sv */
// testbench for the per-thread shadow call stack: directed and random event items
// with an in-order predictor of slot owners, fills and stack entries
// depends on ptscs_pkg and per_thread_shadow_call_stack_top
`timescale 1ns / 1ps

module tb;
  import ptscs_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE = 24;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [SEL_W-1:0]    slot;
    logic [TID_W-1:0]    owner;
    logic [DEPTH_W-1:0]  depth;
    logic [ADDR_W-1:0]   entry;
  } frame_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [MODE_W-1:0] mode_i;
  logic [TID_W-1:0]  thread_id_i;
  logic [ADDR_W-1:0] func_addr_i;
  logic [SEL_W-1:0]  slot_sel_i;
  logic [LVL_W-1:0]  level_sel_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [SEL_W-1:0]    slot_o;
  logic [TID_W-1:0]    owner_id_o;
  logic [DEPTH_W-1:0]  stack_depth_o;
  logic [ADDR_W-1:0]   entry_addr_o;

  // predicted state of the block
  logic [TID_W-1:0]  owner_of [THREAD_SLOTS];
  int                fill_of  [THREAD_SLOTS];
  logic [ADDR_W-1:0] frames   [THREAD_SLOTS][STACK_DEPTH];

  frame_result_t pending_results[$];
  logic [TID_W-1:0] tid_pool [POOL_SIZE];

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned status_seen [6];
  int unsigned deepest = 0;
  int unsigned cycles = 0;
  int steady_left = 0;

  per_thread_shadow_call_stack_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .thread_id_i   (thread_id_i),
    .func_addr_i   (func_addr_i),
    .slot_sel_i    (slot_sel_i),
    .level_sel_i   (level_sel_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .slot_o        (slot_o),
    .owner_id_o    (owner_id_o),
    .stack_depth_o (stack_depth_o),
    .entry_addr_o  (entry_addr_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ADDR_W-1:0] top_frame(int s);
    if (fill_of[s] == 0) return '0;
    return frames[s][fill_of[s]-1];
  endfunction

  function automatic int owned_slot(logic [TID_W-1:0] tid);
    for (int s = 0; s < THREAD_SLOTS; s++)
      if (owner_of[s] == tid) return s;
    return -1;
  endfunction

  function automatic frame_result_t slot_view(logic [STATUS_W-1:0] st, int s);
    frame_result_t r;
    r.status = st;
    r.slot   = SEL_W'(s);
    r.owner  = owner_of[s];
    r.depth  = DEPTH_W'(fill_of[s]);
    r.entry  = top_frame(s);
    return r;
  endfunction

  // predicts the result of one event item and updates the tracked stacks
  function automatic frame_result_t track_call_event(logic [MODE_W-1:0] mode,
      logic [TID_W-1:0] tid, logic [ADDR_W-1:0] addr, logic [SEL_W-1:0] ssel,
      logic [LVL_W-1:0] lsel);
    frame_result_t r;
    int s;
    r = '{STS_RANGE, '0, '0, '0, '0};
    case (mode)
      MODE_ENTER: begin
        if (tid == '0) begin
          r.status = STS_NOT_FOUND;
          return r;
        end
        s = owned_slot(tid);
        if (s < 0) s = owned_slot('0);
        if (s < 0) begin
          r.status = STS_FULL;
          return r;
        end
        if (fill_of[s] >= STACK_DEPTH) return slot_view(STS_OVERFLOW, s);
        frames[s][fill_of[s]] = addr;
        fill_of[s]++;
        owner_of[s] = tid;
        if (fill_of[s] > deepest) deepest = fill_of[s];
        return slot_view(STS_OK, s);
      end
      MODE_EXIT: begin
        s = (tid == '0) ? -1 : owned_slot(tid);
        // emptiness goes before the address compare
        if (s < 0 || fill_of[s] == 0) begin
          r.status = STS_NOT_FOUND;
          return r;
        end
        if (top_frame(s) != addr) return slot_view(STS_MISMATCH, s);
        fill_of[s]--;
        if (fill_of[s] == 0) owner_of[s] = '0;
        return slot_view(STS_OK, s);
      end
      MODE_READ: begin
        r.slot = ssel;
        if (ssel >= THREAD_SLOTS) return r;
        r.owner = owner_of[ssel];
        r.depth = DEPTH_W'(fill_of[ssel]);
        if (lsel >= fill_of[ssel]) return r;
        r.status = STS_OK;
        r.entry  = frames[ssel][fill_of[ssel] - 1 - lsel];
        return r;
      end
      default: return r;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches < 40)
      $display("mismatch on %s at cycle %0d: got %0h, want %0h", what, cycles, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : scoreboard
    frame_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected item", 64'(status_o), '0);
        end else begin
          want = pending_results.pop_front();
          if (want.status < 6) status_seen[want.status]++;
          if (status_o !== want.status)
            report_mismatch("status", 64'(status_o), 64'(want.status));
          if (slot_o !== want.slot) report_mismatch("slot", 64'(slot_o), 64'(want.slot));
          if (owner_id_o !== want.owner)
            report_mismatch("owner_id", 64'(owner_id_o), 64'(want.owner));
          if (stack_depth_o !== want.depth)
            report_mismatch("stack_depth", 64'(stack_depth_o), 64'(want.depth));
          if (entry_addr_o !== want.entry)
            report_mismatch("entry_addr", entry_addr_o, want.entry);
        end
      end
      if (in_valid_i && !in_stall_o)
        pending_results.push_back(track_call_event(mode_i, thread_id_i, func_addr_i,
                                                   slot_sel_i, level_sel_i));
    end
  end

  // receiver back-pressure: short stalls mostly, some long ones, some free stretches
  initial begin : receiver_pace
    int hold;
    int free_run;
    hold = 0;
    free_run = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else if (free_run > 0) begin
        out_stall_i <= 1'b0;
        free_run--;
      end else if ($urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b0;
        free_run = $urandom_range(20, 60);
      end else begin
        out_stall_i <= 1'b0;
        hold = pick_gap();
        free_run = $urandom_range(0, 3);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_event(logic [MODE_W-1:0] mode, logic [TID_W-1:0] tid,
                            logic [ADDR_W-1:0] addr, logic [SEL_W-1:0] ssel,
                            logic [LVL_W-1:0] lsel);
    int gap;
    gap = (steady_left > 0) ? 0 : pick_gap();
    if (steady_left > 0) steady_left--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    thread_id_i <= tid;
    func_addr_i <= addr;
    slot_sel_i  <= ssel;
    level_sel_i <= lsel;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_directed_edges();
    logic [TID_W-1:0] tmax;
    logic [ADDR_W-1:0] mid;
    tmax = '1;
    mid  = 64'hA5A5_5A5A_F00D_0FF0;
    send_event(MODE_READ, TID_W'($urandom), rand_addr(), '0, '0);
    send_event(MODE_READ, TID_W'($urandom), rand_addr(), '1, '1);
    send_event(MODE_UNUSED, TID_W'($urandom), rand_addr(), SEL_W'($urandom),
               LVL_W'($urandom));
    send_event(MODE_ENTER, '0, rand_addr(), '0, '0);
    send_event(MODE_EXIT, '0, rand_addr(), '0, '0);
    send_event(MODE_EXIT, TID_W'(1), '0, '0, '0);
    send_event(MODE_ENTER, TID_W'(1), '0, '1, '1);
    send_event(MODE_ENTER, tmax, '1, '0, '0);
    send_event(MODE_ENTER, TID_W'(1), mid, '0, '0);
    send_event(MODE_READ, '0, '0, SEL_W'(0), LVL_W'(0));
    send_event(MODE_READ, '0, '0, SEL_W'(0), LVL_W'(1));
    send_event(MODE_READ, '0, '0, SEL_W'(0), LVL_W'(2));
    send_event(MODE_READ, '0, '0, SEL_W'(1), '1);
    send_event(MODE_EXIT, TID_W'(1), ~mid, '0, '0);
    send_event(MODE_EXIT, TID_W'(1), mid, '0, '0);
    send_event(MODE_EXIT, TID_W'(1), '0, '0, '0);
    // slot 0 is free again and is the lowest free one
    send_event(MODE_ENTER, TID_W'(2), rand_addr(), '0, '0);
    send_event(MODE_EXIT, tmax, '1, '0, '0);
    send_event(MODE_EXIT, TID_W'(2), top_frame(0), '0, '0);
    send_event(MODE_EXIT, TID_W'(2), '0, '0, '0);
  endtask

  task automatic test_stack_overflow();
    logic [TID_W-1:0] tid;
    int s;
    tid = TID_W'($urandom_range(1, (1 << TID_W) - 1));
    for (int i = 0; i < STACK_DEPTH; i++)
      send_event(MODE_ENTER, tid, rand_addr(), SEL_W'($urandom), LVL_W'($urandom));
    s = owned_slot(tid);
    send_event(MODE_ENTER, tid, rand_addr(), '0, '0);
    send_event(MODE_READ, '0, '0, SEL_W'(s), '0);
    send_event(MODE_READ, '0, '0, SEL_W'(s), LVL_W'(STACK_DEPTH - 1));
    send_event(MODE_READ, '0, '0, SEL_W'(s), LVL_W'(STACK_DEPTH / 2));
    while (fill_of[s] > 0)
      send_event(MODE_EXIT, tid, top_frame(s), SEL_W'($urandom), LVL_W'($urandom));
  endtask

  task automatic test_table_full();
    logic [TID_W-1:0] tids [THREAD_SLOTS + 1];
    for (int i = 0; i <= THREAD_SLOTS; i++)
      tids[i] = TID_W'((i + 1) << 16) | TID_W'($urandom_range(0, 65535));
    for (int i = 0; i < THREAD_SLOTS; i++)
      send_event(MODE_ENTER, tids[i], rand_addr(), '0, '0);
    send_event(MODE_ENTER, tids[THREAD_SLOTS], rand_addr(), '0, '0);
    send_event(MODE_ENTER, tids[5], rand_addr(), '0, '0);
    send_event(MODE_EXIT, tids[THREAD_SLOTS], rand_addr(), '0, '0);
    send_event(MODE_EXIT, tids[0], ~top_frame(0), '0, '0);
    send_event(MODE_READ, '0, '0, SEL_W'(THREAD_SLOTS - 1), '0);
    for (int s = 0; s < THREAD_SLOTS; s++)
      while (fill_of[s] > 0)
        send_event(MODE_EXIT, owner_of[s], top_frame(s), '0, '0);
  endtask

  function automatic logic [TID_W-1:0] pick_tid();
    // a few threads get most of the traffic so their stacks grow deep
    if ($urandom_range(0, 1) == 0) return tid_pool[$urandom_range(0, 3)];
    return tid_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  task automatic random_event(bit grow);
    int r;
    int s;
    int enter_pct;
    int exit_pct;
    logic [TID_W-1:0] tid;
    logic [ADDR_W-1:0] addr;
    logic [SEL_W-1:0] ssel;
    logic [LVL_W-1:0] lsel;
    r = $urandom_range(0, 99);
    enter_pct = grow ? 60 : 25;
    exit_pct  = grow ? 22 : 57;
    tid  = pick_tid();
    ssel = SEL_W'($urandom);
    lsel = LVL_W'($urandom);
    if (r < enter_pct) begin
      send_event(MODE_ENTER, tid, rand_addr(), ssel, lsel);
    end else if (r < enter_pct + exit_pct) begin
      s = owned_slot(tid);
      if (s < 0) addr = rand_addr();
      else if ($urandom_range(0, 9) != 0) addr = top_frame(s);
      else addr = top_frame(s) ^ (64'd1 << $urandom_range(0, 63));
      send_event(MODE_EXIT, tid, addr, ssel, lsel);
    end else if (r < 97) begin
      if (fill_of[ssel] > 0 && $urandom_range(0, 4) != 0)
        lsel = LVL_W'($urandom_range(0, fill_of[ssel] - 1));
      send_event(MODE_READ, TID_W'($urandom), rand_addr(), ssel, lsel);
    end else begin
      case ($urandom_range(0, 3))
        0: send_event(MODE_UNUSED, TID_W'($urandom), rand_addr(), ssel, lsel);
        1: send_event(MODE_ENTER, '0, rand_addr(), ssel, lsel);
        2: send_event(MODE_EXIT, '0, rand_addr(), ssel, lsel);
        default: send_event(MODE_EXIT, TID_W'($urandom), rand_addr(), ssel, lsel);
      endcase
    end
  endtask

  task automatic test_random_traffic(int n_items);
    bit grow;
    grow = 1'b1;
    for (int k = 0; k < n_items; k++) begin
      if (k % 60 == 0) grow = ((k / 60) % 2 == 0);
      if (k % 150 == 75) steady_left = 30;
      random_event(grow);
    end
  endtask

  initial begin : run
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    mode_i      = MODE_ENTER;
    thread_id_i = '0;
    func_addr_i = '0;
    slot_sel_i  = '0;
    level_sel_i = '0;
    for (int s = 0; s < THREAD_SLOTS; s++) begin
      owner_of[s] = '0;
      fill_of[s]  = 0;
    end
    for (int i = 0; i < 6; i++) status_seen[i] = 0;
    tid_pool[0] = TID_W'(1);
    tid_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++)
      tid_pool[i] = TID_W'($urandom_range(1, (1 << TID_W) - 1));
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_edges();
    drain_results();
    test_stack_overflow();
    drain_results();
    test_table_full();
    drain_results();
    test_random_traffic(560);
    drain_results();
    repeat (10) @(negedge clk_i);

    $display("sent %0d items; results ok %0d, full %0d, overflow %0d, not found %0d,",
             items_sent, status_seen[STS_OK], status_seen[STS_FULL],
             status_seen[STS_OVERFLOW], status_seen[STS_NOT_FOUND]);
    $display("mismatch %0d, range %0d; deepest stack %0d; %0d field errors",
             status_seen[STS_MISMATCH], status_seen[STS_RANGE], deepest, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
